// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked concurrent assertions, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked assertion of an implication or expression
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that the consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/imm_pkg.sv -----
// ----------------------------------------------------------------------------
// imm_pkg
// Types and codes for the integer matrix multiply unit.
// ----------------------------------------------------------------------------
package imm_pkg;

  // Input item kinds
  localparam logic [1:0] MODE_LOAD_B  = 2'd0;
  localparam logic [1:0] MODE_LOAD_C  = 2'd1;
  localparam logic [1:0] MODE_COMPUTE = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN
  } imm_state_t;

endpackage

// ----- src/integer_matrix_multiply_unit.sv -----
// ----------------------------------------------------------------------------
// integer_matrix_multiply_unit
// Signed 32-bit matrix product A = B x C, wrapping modulo 2^32. Loads fill
// B or C one element at a time; a compute request streams one row of A.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Transfer  Contents
//  s_*      in   item      tuser: mode; tdata: row, col, value
//  m_*      out  result    tdata: result_value, result_col; tlast: last
//
// A row request runs one multiply-accumulate unit that walks k for each
// column j, fed by one read port on each of the B and C memories, with a drain
// per column through its read, multiply and accumulate registers. s_tready is
// high only while idle. A stalled output holds the next column in the drain
// state until taken.
// rst is synchronous; the B and C memories are not cleared.
`include "assert_macros.svh"

module integer_matrix_multiply_unit
  import imm_pkg::*;
#(
  parameter int ROWS_OUT  = 32,
  parameter int INNER_DIM = 32,
  parameter int COLS_OUT  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [5:0] row, [11:6] col, [43:12] value, zero fill
  input  logic [1:0]  s_tuser,   // [1:0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] result_value, [37:32] result_col, zero fill
  output logic        m_tlast
);

  localparam int BD  = ROWS_OUT * INNER_DIM;
  localparam int CD  = INNER_DIM * COLS_OUT;
  localparam int BAW = (BD > 1) ? $clog2(BD) : 1;
  localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
  localparam int KW  = (INNER_DIM > 1) ? $clog2(INNER_DIM) : 1;

  // Input fields
  logic [5:0]  in_row;
  logic [5:0]  in_col;
  logic [31:0] in_value;
  logic [1:0]  in_mode;
  logic        in_xfer;

  assign in_row   = s_tdata[5:0];
  assign in_col   = s_tdata[11:6];
  assign in_value = s_tdata[43:12];
  assign in_mode  = s_tuser;
  assign in_xfer  = s_tvalid && s_tready;

  // Range checks on the requested element or row
  logic row_lt_rows, row_lt_inner, col_lt_inner, col_lt_cols;
  assign row_lt_rows  = {1'b0, in_row} < 7'(ROWS_OUT);
  assign row_lt_inner = {1'b0, in_row} < 7'(INNER_DIM);
  assign col_lt_inner = {1'b0, in_col} < 7'(INNER_DIM);
  assign col_lt_cols  = {1'b0, in_col} < 7'(COLS_OUT);

  // Registers
  imm_state_t       state, state_next;
  logic [BAW-1:0]   b_base;
  logic [BAW-1:0]   b_addr;
  logic [CAW-1:0]   c_addr;
  logic [KW-1:0]    k;
  logic [5:0]       j;
  logic             rd_vld, rd_last;
  logic [31:0]      prod;
  logic             prod_vld, prod_last;
  logic [31:0]      acc;
  logic             acc_done;
  logic [31:0]      out_value;
  logic [5:0]       out_col;

  // Memory ports
  logic             b_we, c_we;
  logic [BAW-1:0]   b_waddr;
  logic [CAW-1:0]   c_waddr;
  logic [31:0]      b_q, c_q;
  logic [31:0]      mul_lo;

  assign b_we    = in_xfer && (in_mode == MODE_LOAD_B) && row_lt_rows && col_lt_inner;
  assign c_we    = in_xfer && (in_mode == MODE_LOAD_C) && row_lt_inner && col_lt_cols;
  assign b_waddr = BAW'(in_row * INNER_DIM + in_col);
  assign c_waddr = CAW'(in_row * COLS_OUT + in_col);

  imm_ram #(.WIDTH(32), .DEPTH(BD)) u_b_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (in_value),
    .raddr (b_addr),
    .rdata (b_q)
  );

  imm_ram #(.WIDTH(32), .DEPTH(CD)) u_c_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (in_value),
    .raddr (c_addr),
    .rdata (c_q)
  );

  // Low half of the product is all that survives the wrap
  assign mul_lo = b_q * c_q;

  // Control signals
  logic start, issue, k_last, out_free, col_push, j_last;

  assign k_last   = (k == KW'(INNER_DIM - 1));
  assign j_last   = (j == 6'(COLS_OUT - 1));
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign start    = in_xfer && (in_mode == MODE_COMPUTE) && row_lt_rows;

  // Next state and strobes
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    col_push   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        issue = 1'b1;
        if (k_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (acc_done && out_free) begin
          col_push   = 1'b1;
          state_next = j_last ? ST_IDLE : ST_MAC;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
      acc_done <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_vld   <= issue;
      prod_vld <= rd_vld;
      if (col_push) begin
        acc_done <= 1'b0;
      end else if (prod_vld && prod_last) begin
        acc_done <= 1'b1;
      end
      if (col_push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Address walk, multiply and accumulate
  always_ff @(posedge clk) begin
    rd_last   <= issue && k_last;
    prod      <= mul_lo;
    prod_last <= rd_last;
    if (start) begin
      b_base <= BAW'(in_row * INNER_DIM);
      b_addr <= BAW'(in_row * INNER_DIM);
      c_addr <= '0;
      k      <= '0;
      j      <= '0;
      acc    <= '0;
    end else begin
      if (issue) begin
        k      <= k_last ? '0 : k + 1'b1;
        b_addr <= b_addr + 1'b1;
        c_addr <= CAW'(c_addr + COLS_OUT);
      end
      if (col_push) begin
        acc    <= '0;
        j      <= j + 1'b1;
        b_addr <= b_base;
        c_addr <= CAW'(j + 1'b1);
      end else if (prod_vld) begin
        acc <= acc + prod;
      end
    end
    if (col_push) begin
      out_value <= acc;
      out_col   <= j;
    end
  end

  // Output channel
  always_comb begin
    m_tdata = {2'b00, out_col, out_value};
  end

  logic out_last;
  always_ff @(posedge clk) begin
    if (col_push) begin
      out_last <= j_last;
    end
  end
  assign m_tlast = out_last;

  // Checks
  `ASSERT_CLK(a_done_in_drain, acc_done |-> (state == ST_DRAIN), "column done outside drain")
  `ASSERT_CLK(a_prod_busy, prod_vld |-> (state == ST_MAC || state == ST_DRAIN), "stray product")
  `ASSERT_NEXT(a_push_shows, col_push, m_tvalid && (out_value == $past(acc)), "result not loaded")

endmodule

// ----- src/imm_ram.sv -----
// ----------------------------------------------------------------------------
// imm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/sv/tb_integer_matrix_multiply_unit.sv -----
// ----------------------------------------------------------------------------
// tb_integer_matrix_multiply_unit
// Self-checking bench for the integer matrix multiply unit. All of C, and every
// B row that is requested, is loaded in full before the row is requested, so no
// unwritten element is ever read. A behavioral copy of B and C predicts every
// row of A. Each result transfer is checked against the oldest prediction in order.
// ----------------------------------------------------------------------------
module tb_integer_matrix_multiply_unit;
  import imm_pkg::*;

  localparam int ROWS_OUT  = 32;
  localparam int INNER_DIM = 32;
  localparam int COLS_OUT  = 32;

  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam logic [31:0] VAL_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN     = 32'h8000_0000;
  localparam logic [31:0] VAL_NEG1    = 32'hFFFF_FFFF;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          ROW_LATENCY = COLS_OUT * (INNER_DIM + 3) + 100;
  localparam int          MAX_REPORTS = 10;

  // One element of an emitted row of A
  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  col;
    logic        last;
  } a_elem_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // [5:0] row, [11:6] col, [43:12] value, zero fill
  logic [1:0]  s_tuser = '0;   // [1:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [31:0] result_value, [37:32] result_col, zero fill
  logic        m_tlast;

  // Behavioral copy of the operand memories
  logic [31:0] b_matrix [ROWS_OUT][INNER_DIM];
  logic [31:0] c_matrix [INNER_DIM][COLS_OUT];
  bit          b_loaded [ROWS_OUT][INNER_DIM];

  a_elem_t pending_row_elems [$];

  int send_idle_pct = 29;
  int recv_idle_pct = 58;
  int error_count   = 0;
  int cycle_count   = 0;

  integer_matrix_multiply_unit #(
    .ROWS_OUT  (ROWS_OUT),
    .INNER_DIM (INNER_DIM),
    .COLS_OUT  (COLS_OUT)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Wrapped dot product of row r of B with column c of C
  function automatic logic [31:0] row_col_dot(int r, int c);
    logic [31:0] acc;
    acc = '0;
    for (int k = 0; k < INNER_DIM; k++) begin
      acc = acc + b_matrix[r][k] * c_matrix[k][c];
    end
    return acc;
  endfunction

  function automatic bit b_row_complete(int r);
    for (int k = 0; k < INNER_DIM; k++) begin
      if (!b_loaded[r][k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Apply one accepted item to the matrix copy; a row request queues its results
  task automatic apply_matrix_item(logic [1:0] mode, logic [5:0] row, logic [5:0] col,
                                   logic [31:0] value);
    a_elem_t elem;
    case (mode)
      MODE_LOAD_B: begin
        if (row < ROWS_OUT && col < INNER_DIM) begin
          b_matrix[row][col] = value;
          b_loaded[row][col] = 1'b1;
        end
      end
      MODE_LOAD_C: begin
        if (row < INNER_DIM && col < COLS_OUT) c_matrix[row][col] = value;
      end
      MODE_COMPUTE: begin
        if (row < ROWS_OUT) begin
          for (int j = 0; j < COLS_OUT; j++) begin
            elem.value = row_col_dot(row, j);
            elem.col   = j[5:0];
            elem.last  = (j == COLS_OUT - 1);
            pending_row_elems.push_back(elem);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Drive one item, with a random gap before it, and wait for its transfer
  task automatic send_item(logic [1:0] mode, logic [5:0] row, logic [5:0] col,
                           logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {4'b0, value, col, row};
    do @(posedge clk); while (!s_tready);
    apply_matrix_item(mode, row, col, value);
  endtask

  // Hold the input side until every predicted element has arrived
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_row_elems.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch %s: expected %0h actual %0h", what, exp_v, act_v);
  endtask

  // Result checker and output backpressure
  always @(posedge clk) begin
    a_elem_t exp_elem;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_row_elems.size() == 0) begin
          report_mismatch("unexpected transfer", '0, {24'b0, m_tdata});
        end else begin
          exp_elem = pending_row_elems.pop_front();
          if (m_tdata[31:0] !== exp_elem.value)
            report_mismatch("result_value", 64'(exp_elem.value), 64'(m_tdata[31:0]));
          if (m_tdata[37:32] !== exp_elem.col)
            report_mismatch("result_col", 64'(exp_elem.col), 64'(m_tdata[37:32]));
          if (m_tlast !== exp_elem.last)
            report_mismatch("last", 64'(exp_elem.last), 64'(m_tlast));
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Full C with extreme columns, and B rows of max, min, -1 and random values
  task automatic test_load_operands();
    logic [31:0] v;
    for (int k = 0; k < INNER_DIM; k++) begin
      for (int j = 0; j < COLS_OUT; j++) begin
        case (j)
          0:       v = VAL_MAX;
          1:       v = VAL_MIN;
          2:       v = VAL_NEG1;
          3:       v = '0;
          default: v = $urandom;
        endcase
        send_item(MODE_LOAD_C, k[5:0], j[5:0], v);
      end
    end
    for (int k = 0; k < INNER_DIM; k++) begin
      send_item(MODE_LOAD_B, 6'd0, k[5:0], VAL_MAX);
      send_item(MODE_LOAD_B, 6'd1, k[5:0], VAL_MIN);
      send_item(MODE_LOAD_B, 6'd2, k[5:0], VAL_NEG1);
      send_item(MODE_LOAD_B, 6'd31, k[5:0], $urandom);
    end
  endtask

  // Rows whose sums overflow and wrap
  task automatic test_extreme_rows();
    send_item(MODE_COMPUTE, 6'd0, 6'd0, '0);
    send_item(MODE_COMPUTE, 6'd1, 6'd63, VAL_NEG1);
    send_item(MODE_COMPUTE, 6'd2, 6'd0, '0);
    send_item(MODE_COMPUTE, 6'd31, 6'd0, '0);
  endtask

  // Out-of-range loads and requests, and the unused mode, change nothing
  task automatic test_ignored_items();
    send_item(MODE_LOAD_B, 6'd32, 6'd0, VAL_MIN);
    send_item(MODE_LOAD_B, 6'd0, 6'd32, VAL_MIN);
    send_item(MODE_LOAD_C, 6'd63, 6'd63, VAL_MIN);
    send_item(MODE_LOAD_C, 6'd0, 6'd40, VAL_MIN);
    send_item(MODE_COMPUTE, 6'd32, 6'd0, '0);
    send_item(MODE_COMPUTE, 6'd63, 6'd63, VAL_NEG1);
    send_item(MODE_UNUSED, 6'd0, 6'd0, VAL_NEG1);
    send_item(MODE_UNUSED, 6'd63, 6'd63, VAL_MAX);
    send_item(MODE_COMPUTE, 6'd0, 6'd0, '0);
  endtask

  // Overwrite corner elements, then request after the pipe is empty
  task automatic test_overwrite();
    send_item(MODE_LOAD_B, 6'd0, 6'd31, '0);
    send_item(MODE_LOAD_C, 6'd31, 6'd31, VAL_MAX);
    send_item(MODE_LOAD_C, 6'd0, 6'd0, 32'd1);
    drain_results();
    send_item(MODE_COMPUTE, 6'd0, 6'd0, '0);
    send_item(MODE_COMPUTE, 6'd0, 6'd0, '0);
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(7))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return VAL_NEG1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly row requests on complete rows and in-range loads, some noise
  task automatic test_random_traffic(int n_items);
    int          counted;
    int          pick;
    int          r;
    logic [5:0]  row;
    logic [5:0]  col;
    counted = 0;
    while (counted < n_items) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        if ($urandom_range(4) == 0) begin
          send_item(MODE_COMPUTE, 6'($urandom_range(63, ROWS_OUT)), 6'($urandom), $urandom);
        end else begin
          do r = $urandom_range(ROWS_OUT - 1); while (!b_row_complete(r));
          send_item(MODE_COMPUTE, r[5:0], 6'($urandom), $urandom);
          counted++;
        end
      end else if (pick < 65) begin
        row = 6'($urandom);
        col = 6'($urandom);
        if ($urandom_range(9) < 7) begin
          row = 6'($urandom_range(ROWS_OUT - 1));
          col = 6'($urandom_range(INNER_DIM - 1));
        end
        send_item(MODE_LOAD_B, row, col, random_value());
        if (row < ROWS_OUT && col < INNER_DIM) counted++;
      end else if (pick < 90) begin
        row = 6'($urandom);
        col = 6'($urandom);
        if ($urandom_range(9) < 7) begin
          row = 6'($urandom_range(INNER_DIM - 1));
          col = 6'($urandom_range(COLS_OUT - 1));
        end
        send_item(MODE_LOAD_C, row, col, random_value());
        if (row < INNER_DIM && col < COLS_OUT) counted++;
      end else begin
        send_item(MODE_UNUSED, 6'($urandom), 6'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_load_operands();
    test_extreme_rows();
    test_ignored_items();
    test_overwrite();
    test_random_traffic(40);

    send_idle_pct = 58;
    recv_idle_pct = 29;
    test_random_traffic(40);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(40);

    // Wait out the last row, then watch for stray transfers
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_row_elems.size() != 0) @(posedge clk);
    repeat (ROW_LATENCY) @(posedge clk);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
